/* sv/prrts_pkg.sv */
// ---------------------------------------------------------------------------
// prrts_pkg
// Shared types, codes and defaults for the priority round-robin scheduler.
// ---------------------------------------------------------------------------
package prrts_pkg;

    // default sizes
    localparam int MAX_TASKS_DEF  = 16;
    localparam int NUM_LEVELS_DEF = 32;

    // operation codes
    localparam logic [2:0] FN_CREATE = 3'd0;
    localparam logic [2:0] FN_START  = 3'd1;
    localparam logic [2:0] FN_YIELD  = 3'd2;
    localparam logic [2:0] FN_DELAY  = 3'd3;
    localparam logic [2:0] FN_TICK   = 3'd4;

    // create result codes
    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_RANGE = 2'd1;
    localparam logic [1:0] ERR_FULL  = 2'd2;

    // per-task state
    typedef enum logic [1:0] {
        TS_SUSPENDED,
        TS_READY,
        TS_RUNNING,
        TS_BLOCKED
    } task_state_t;

    // index of the lowest set bit, zero when none is set
    function automatic logic [4:0] lowest_set(input logic [31:0] v);
        logic [4:0] r;
        r = '0;
        for (int i = 31; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = 5'(i);
            end
        end
        return r;
    endfunction

endpackage

/* sv/prrts_mod_unit.sv */
// ---------------------------------------------------------------------------
// prrts_mod_unit
// Iterative remainder unit: one compare and subtract per cycle.
// ---------------------------------------------------------------------------
module prrts_mod_unit #(
    parameter int W = 5
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] remainder
);

    logic         run_reg;
    logic [W-1:0] rem_reg;
    logic [W-1:0] div_reg;

    // finished when the remainder drops below the divisor
    assign done      = run_reg && (rem_reg < div_reg);
    assign remainder = rem_reg;

    // subtract loop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
        end
        else if (start)
        begin
            run_reg <= 1'b1;
        end
        else if (done)
        begin
            run_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend;
            div_reg <= divisor;
        end
        else if (run_reg && !done)
        begin
            rem_reg <= rem_reg - div_reg;
        end
    end

endmodule

/* sv/priority_round_robin_task_scheduler.sv */
// ---------------------------------------------------------------------------
// priority_round_robin_task_scheduler
// Task scheduler with priority levels and round robin within a level.
//
// channel   direction  handshake            payload
// command   in         start, busy          func, priority_req, block_ticks
// result    out        done (one cycle)     current_task, switch_request,
//                                           error_code, new_task_id,
//                                           ready_levels, ticks_elapsed,
//                                           tasks_in_use
//
// Create and unknown operations go straight to done. Selection walks the
// created task entries twice (count, then pick) plus an iterative remainder
// loop; a tick walks the entries once more and may count again. The longest
// case is a delay that blocks the running task; its length is set by the
// entry scan counter and remainder loop.
// Reset is asynchronous; no clearing pass is needed. busy is high from
// acceptance to the cycle with done; results cannot be stalled.
// ---------------------------------------------------------------------------
module priority_round_robin_task_scheduler #(
    parameter int MAX_TASKS  = prrts_pkg::MAX_TASKS_DEF,
    parameter int NUM_LEVELS = prrts_pkg::NUM_LEVELS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  func,
    input  logic [5:0]  priority_req,
    input  logic [31:0] block_ticks,
    output logic        done,
    output logic [4:0]  current_task,
    output logic        switch_request,
    output logic [1:0]  error_code,
    output logic [3:0]  new_task_id,
    output logic [31:0] ready_levels,
    output logic [31:0] ticks_elapsed,
    output logic [4:0]  tasks_in_use
);

    localparam int IDXW = $clog2(MAX_TASKS);
    localparam int CNTW = $clog2(MAX_TASKS + 1);
    localparam int IDW  = $clog2(MAX_TASKS + 2);
    localparam int PW   = $clog2(NUM_LEVELS);
    localparam logic [IDW-1:0] IDLE_ID = IDW'(MAX_TASKS);
    localparam logic [IDW-1:0] NONE_ID = IDW'(MAX_TASKS + 1);
    localparam logic [PW-1:0]  IDLE_PRIO = PW'(NUM_LEVELS - 1);

    typedef enum logic [2:0] {
        S_IDLE, S_SEL, S_CNT, S_MOD, S_PICK, S_SET, S_TICK, S_DONE
    } seq_t;

    typedef enum logic [1:0] {
        M_SEL, M_DLY, M_TICK
    } mode_t;

    seq_t  state_reg, state_next;
    mode_t mode_reg, mode_next;

    prrts_pkg::task_state_t tstate_reg [MAX_TASKS];
    prrts_pkg::task_state_t tstate_next [MAX_TASKS];
    logic [PW-1:0]   prio_reg [MAX_TASKS];
    logic [PW-1:0]   prio_next [MAX_TASKS];
    logic [31:0]     delay_reg [MAX_TASKS];
    logic [31:0]     delay_next [MAX_TASKS];
    logic [IDXW-1:0] rot_reg [NUM_LEVELS];
    logic [IDXW-1:0] rot_next [NUM_LEVELS];

    logic [31:0]     bitmap_reg, bitmap_next;
    logic [IDW-1:0]  running_reg, running_next;
    logic [PW-1:0]   run_prio_reg, run_prio_next;
    logic [CNTW-1:0] total_reg, total_next;
    logic [31:0]     tick_reg, tick_next;
    logic            sw_reg, sw_next;
    logic [1:0]      err_reg, err_next;
    logic [IDXW-1:0] newid_reg, newid_next;

    logic [CNTW-1:0] scan_reg, scan_next;
    logic [CNTW-1:0] n_reg, n_next;
    logic [CNTW-1:0] k_reg, k_next;
    logic [PW-1:0]   cnt_prio_reg, cnt_prio_next;
    logic [IDW-1:0]  pick_reg, pick_next;

    logic            mod_start;
    logic            mod_done;
    logic [CNTW-1:0] mod_rem;

    logic [IDXW-1:0] idx;
    logic [IDXW-1:0] run_idx;
    logic [IDXW-1:0] tot_idx;
    logic            act;
    logic [4:0]      low_lvl;
    logic [31:0]     dec;

    function automatic logic [IDXW-1:0] rot_inc(input logic [IDXW-1:0] x);
        return (x == IDXW'(MAX_TASKS - 1)) ? '0 : x + IDXW'(1);
    endfunction

    assign idx     = scan_reg[IDXW-1:0];
    assign run_idx = running_reg[IDXW-1:0];
    assign tot_idx = total_reg[IDXW-1:0];
    assign act     = (prio_reg[idx] == cnt_prio_reg) &&
                     (tstate_reg[idx] == prrts_pkg::TS_READY ||
                      tstate_reg[idx] == prrts_pkg::TS_RUNNING);
    assign low_lvl = prrts_pkg::lowest_set(bitmap_reg);
    assign dec     = delay_reg[idx] - 32'd1;

    // shared remainder unit for the rotation position
    prrts_mod_unit #(
        .W(CNTW)
    ) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (CNTW'(rot_reg[cnt_prio_reg])),
        .divisor  (n_reg),
        .done     (mod_done),
        .remainder(mod_rem)
    );

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        tstate_next   = tstate_reg;
        prio_next     = prio_reg;
        delay_next    = delay_reg;
        rot_next      = rot_reg;
        bitmap_next   = bitmap_reg;
        running_next  = running_reg;
        run_prio_next = run_prio_reg;
        total_next    = total_reg;
        tick_next     = tick_reg;
        sw_next       = sw_reg;
        err_next      = err_reg;
        newid_next    = newid_reg;
        scan_next     = scan_reg;
        n_next        = n_reg;
        k_next        = k_reg;
        cnt_prio_next = cnt_prio_reg;
        pick_next     = pick_reg;
        mod_start     = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    sw_next    = 1'b0;
                    err_next   = prrts_pkg::ERR_OK;
                    newid_next = '0;
                    state_next = S_DONE;
                    case (func)
                        prrts_pkg::FN_CREATE:
                        begin
                            if (32'(priority_req) >= NUM_LEVELS)
                            begin
                                err_next = prrts_pkg::ERR_RANGE;
                            end
                            else if (total_reg >= CNTW'(MAX_TASKS))
                            begin
                                err_next = prrts_pkg::ERR_FULL;
                            end
                            else
                            begin
                                newid_next           = tot_idx;
                                prio_next[tot_idx]   = PW'(priority_req);
                                delay_next[tot_idx]  = '0;
                                tstate_next[tot_idx] = prrts_pkg::TS_READY;
                                bitmap_next = bitmap_reg | (32'd1 << priority_req[4:0]);
                                total_next  = total_reg + CNTW'(1);
                            end
                        end
                        prrts_pkg::FN_START:
                        begin
                            sw_next    = 1'b1;
                            state_next = S_SEL;
                        end
                        prrts_pkg::FN_YIELD:
                        begin
                            sw_next    = 1'b1;
                            state_next = S_SEL;
                            if (running_reg != NONE_ID)
                            begin
                                rot_next[run_prio_reg] = rot_inc(rot_reg[run_prio_reg]);
                            end
                        end
                        prrts_pkg::FN_DELAY:
                        begin
                            sw_next = 1'b1;
                            if (block_ticks == 32'd0)
                            begin
                                state_next = S_SEL;
                                if (running_reg != NONE_ID)
                                begin
                                    rot_next[run_prio_reg] =
                                        rot_inc(rot_reg[run_prio_reg]);
                                end
                            end
                            else if (running_reg < IDLE_ID)
                            begin
                                tstate_next[run_idx] = prrts_pkg::TS_BLOCKED;
                                delay_next[run_idx]  = block_ticks;
                                cnt_prio_next = run_prio_reg;
                                mode_next     = M_DLY;
                                scan_next     = '0;
                                n_next        = '0;
                                state_next    = S_CNT;
                            end
                        end
                        prrts_pkg::FN_TICK:
                        begin
                            tick_next  = tick_reg + 32'd1;
                            scan_next  = '0;
                            state_next = S_TICK;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            // highest ready level
            S_SEL:
            begin
                if (bitmap_reg == 32'd0 || 32'(low_lvl) >= NUM_LEVELS)
                begin
                    pick_next  = IDLE_ID;
                    state_next = S_SET;
                end
                else
                begin
                    cnt_prio_next = PW'(low_lvl);
                    mode_next     = M_SEL;
                    scan_next     = '0;
                    n_next        = '0;
                    state_next    = S_CNT;
                end
            end

            // count active tasks at one level, then select, update the level bit or rotate by mode
            S_CNT:
            begin
                if (scan_reg < total_reg)
                begin
                    if (act)
                    begin
                        n_next = n_reg + CNTW'(1);
                    end
                    scan_next = scan_reg + CNTW'(1);
                end
                else
                begin
                    case (mode_reg)
                        M_SEL:
                        begin
                            if (n_reg == '0)
                            begin
                                pick_next  = IDLE_ID;
                                state_next = S_SET;
                            end
                            else
                            begin
                                mod_start  = 1'b1;
                                state_next = S_MOD;
                            end
                        end
                        M_DLY:
                        begin
                            if (n_reg != '0)
                            begin
                                bitmap_next = bitmap_reg | (32'd1 << 5'(cnt_prio_reg));
                            end
                            else
                            begin
                                bitmap_next = bitmap_reg & ~(32'd1 << 5'(cnt_prio_reg));
                            end
                            state_next = S_SEL;
                        end
                        default:
                        begin
                            if (n_reg > CNTW'(1))
                            begin
                                rot_next[cnt_prio_reg] = rot_inc(rot_reg[cnt_prio_reg]);
                                sw_next = 1'b1;
                            end
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            // rotation position modulo count
            S_MOD:
            begin
                if (mod_done)
                begin
                    k_next     = mod_rem;
                    scan_next  = '0;
                    n_next     = '0;
                    state_next = S_PICK;
                end
            end

            // walk to the chosen active task; n counts passed actives
            S_PICK:
            begin
                if (scan_reg < total_reg)
                begin
                    if (act)
                    begin
                        if (n_reg == k_reg)
                        begin
                            pick_next  = IDW'(scan_reg);
                            state_next = S_SET;
                        end
                        n_next = n_reg + CNTW'(1);
                    end
                    scan_next = scan_reg + CNTW'(1);
                end
                else
                begin
                    pick_next  = IDLE_ID;
                    state_next = S_SET;
                end
            end

            // hand over the processor
            S_SET:
            begin
                if (running_reg < IDLE_ID && tstate_reg[run_idx] == prrts_pkg::TS_RUNNING)
                begin
                    tstate_next[run_idx] = prrts_pkg::TS_READY;
                end
                if (pick_reg < IDLE_ID)
                begin
                    tstate_next[pick_reg[IDXW-1:0]] = prrts_pkg::TS_RUNNING;
                    run_prio_next = cnt_prio_reg;
                end
                else
                begin
                    run_prio_next = IDLE_PRIO;
                end
                running_next = pick_reg;
                state_next   = S_DONE;
            end

            // count down blocked tasks
            S_TICK:
            begin
                if (scan_reg < total_reg)
                begin
                    if (tstate_reg[idx] == prrts_pkg::TS_BLOCKED && delay_reg[idx] != 32'd0)
                    begin
                        delay_next[idx] = dec;
                        if (dec == 32'd0)
                        begin
                            tstate_next[idx] = prrts_pkg::TS_READY;
                            bitmap_next = bitmap_reg | (32'd1 << 5'(prio_reg[idx]));
                            if (running_reg != NONE_ID && prio_reg[idx] < run_prio_reg)
                            begin
                                sw_next = 1'b1;
                            end
                        end
                    end
                    scan_next = scan_reg + CNTW'(1);
                end
                else if (running_reg != NONE_ID)
                begin
                    cnt_prio_next = run_prio_reg;
                    mode_next     = M_TICK;
                    scan_next     = '0;
                    n_next        = '0;
                    state_next    = S_CNT;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state and reset-cleared tables
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            mode_reg     <= M_SEL;
            bitmap_reg   <= '0;
            running_reg  <= NONE_ID;
            run_prio_reg <= IDLE_PRIO;
            total_reg    <= '0;
            tick_reg     <= '0;
            sw_reg       <= 1'b0;
            err_reg      <= prrts_pkg::ERR_OK;
            newid_reg    <= '0;
            for (int i = 0; i < MAX_TASKS; i++)
            begin
                tstate_reg[i] <= prrts_pkg::TS_SUSPENDED;
            end
            for (int j = 0; j < NUM_LEVELS; j++)
            begin
                rot_reg[j] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            mode_reg     <= mode_next;
            bitmap_reg   <= bitmap_next;
            running_reg  <= running_next;
            run_prio_reg <= run_prio_next;
            total_reg    <= total_next;
            tick_reg     <= tick_next;
            sw_reg       <= sw_next;
            err_reg      <= err_next;
            newid_reg    <= newid_next;
            tstate_reg   <= tstate_next;
            rot_reg      <= rot_next;
        end
    end

    // payload tables and scan working registers
    always_ff @(posedge clk)
    begin
        prio_reg     <= prio_next;
        delay_reg    <= delay_next;
        scan_reg     <= scan_next;
        n_reg        <= n_next;
        k_reg        <= k_next;
        cnt_prio_reg <= cnt_prio_next;
        pick_reg     <= pick_next;
    end

    // result word
    assign busy           = (state_reg != S_IDLE);
    assign done           = (state_reg == S_DONE);
    assign current_task   = 5'(running_reg);
    assign switch_request = sw_reg;
    assign error_code     = err_reg;
    assign new_task_id    = 4'(newid_reg);
    assign ready_levels   = bitmap_reg;
    assign ticks_elapsed  = tick_reg;
    assign tasks_in_use   = 5'(total_reg);

endmodule

/* tb/sv/testbench.sv */
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the priority round-robin task scheduler. A local
// model tracks task states, the level bitmap and the rotation indexes and
// predicts every result word; directed cases are followed by random traffic
// with random gaps on the command side.
// ---------------------------------------------------------------------------
module testbench;

    localparam int NT      = prrts_pkg::MAX_TASKS_DEF;
    localparam int NL      = prrts_pkg::NUM_LEVELS_DEF;
    localparam int IDLE    = NT;
    localparam int NONE    = NT + 1;
    localparam int WDOG    = 4000;
    localparam int SETTLE  = 4 * NT + 16;

    typedef struct {
        logic [4:0]  cur;
        logic        sw;
        logic [1:0]  err;
        logic [3:0]  id;
        logic [31:0] levels;
        logic [31:0] ticks;
        logic [4:0]  total;
    } sched_word_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  func;
    logic [5:0]  priority_req;
    logic [31:0] block_ticks;
    logic        done;
    logic [4:0]  current_task;
    logic        switch_request;
    logic [1:0]  error_code;
    logic [3:0]  new_task_id;
    logic [31:0] ready_levels;
    logic [31:0] ticks_elapsed;
    logic [4:0]  tasks_in_use;

    // scheduler model state
    logic [4:0]  m_prio [NT];
    prrts_pkg::task_state_t m_state [NT];
    logic [31:0] m_wait [NT];
    logic [3:0]  m_rot [NL];
    logic [31:0] m_levels;
    int          m_run;
    int          m_total;
    logic [31:0] m_ticks;

    sched_word_t expected_words [$];
    int          n_sent;
    int          n_checked;
    int          n_errors;
    int          n_switches;
    int          quiet_cycles;

    priority_round_robin_task_scheduler dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .func(func), .priority_req(priority_req), .block_ticks(block_ticks),
        .done(done), .current_task(current_task),
        .switch_request(switch_request), .error_code(error_code),
        .new_task_id(new_task_id), .ready_levels(ready_levels),
        .ticks_elapsed(ticks_elapsed), .tasks_in_use(tasks_in_use)
    );

    // clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic bit runnable_at(int i, int p);
        return m_prio[i] == p && (m_state[i] == prrts_pkg::TS_READY ||
                                  m_state[i] == prrts_pkg::TS_RUNNING);
    endfunction

    function automatic int level_of(int id);
        return (id < NT) ? int'(m_prio[id]) : NL - 1;
    endfunction

    function automatic int peers_at(int p);
        int n;
        n = 0;
        for (int i = 0; i < m_total; i++)
        begin
            if (runnable_at(i, p))
                n++;
        end
        return n;
    endfunction

    function automatic int pick_next();
        int p;
        int n;
        int pos;
        int k;
        if (m_levels == 0)
            return IDLE;
        p = 0;
        while (!m_levels[p])
            p++;
        n = peers_at(p);
        if (n == 0)
            return IDLE;
        pos = int'(m_rot[p]) % n;
        k = 0;
        for (int i = 0; i < m_total; i++)
        begin
            if (runnable_at(i, p))
            begin
                if (k == pos)
                    return i;
                k++;
            end
        end
        return IDLE;
    endfunction

    function automatic void dispatch(int nxt);
        if (m_run < NT && m_state[m_run] == prrts_pkg::TS_RUNNING)
            m_state[m_run] = prrts_pkg::TS_READY;
        if (nxt < NT)
            m_state[nxt] = prrts_pkg::TS_RUNNING;
        m_run = nxt;
    endfunction

    function automatic void rotate_and_pick();
        if (m_run != NONE)
            m_rot[level_of(m_run)] = m_rot[level_of(m_run)] + 4'd1;
        dispatch(pick_next());
    endfunction

    // apply one command word to the model and return the result word
    function automatic sched_word_t schedule_step(logic [2:0] f, logic [5:0] p,
                                                  logic [31:0] d);
        sched_word_t w;
        int pr;
        w.sw = 1'b0;
        w.err = prrts_pkg::ERR_OK;
        w.id = '0;
        case (f)
            prrts_pkg::FN_CREATE:
            begin
                if (p >= NL)
                    w.err = prrts_pkg::ERR_RANGE;
                else if (m_total >= NT)
                    w.err = prrts_pkg::ERR_FULL;
                else
                begin
                    w.id = 4'(m_total);
                    m_prio[m_total] = 5'(p);
                    m_wait[m_total] = '0;
                    m_state[m_total] = prrts_pkg::TS_READY;
                    m_levels[p] = 1'b1;
                    m_total++;
                end
            end
            prrts_pkg::FN_START:
            begin
                dispatch(pick_next());
                w.sw = 1'b1;
            end
            prrts_pkg::FN_YIELD:
            begin
                rotate_and_pick();
                w.sw = 1'b1;
            end
            prrts_pkg::FN_DELAY:
            begin
                if (d == 0)
                    rotate_and_pick();
                else if (m_run < NT)
                begin
                    pr = m_prio[m_run];
                    m_state[m_run] = prrts_pkg::TS_BLOCKED;
                    m_wait[m_run] = d;
                    m_levels[pr] = (peers_at(pr) > 0);
                    dispatch(pick_next());
                end
                w.sw = 1'b1;
            end
            prrts_pkg::FN_TICK:
            begin
                m_ticks++;
                for (int i = 0; i < m_total; i++)
                begin
                    if (m_state[i] == prrts_pkg::TS_BLOCKED && m_wait[i] != 0)
                    begin
                        m_wait[i]--;
                        if (m_wait[i] == 0)
                        begin
                            m_state[i] = prrts_pkg::TS_READY;
                            m_levels[m_prio[i]] = 1'b1;
                            if (m_run != NONE && int'(m_prio[i]) < level_of(m_run))
                                w.sw = 1'b1;
                        end
                    end
                end
                if (m_run != NONE && peers_at(level_of(m_run)) > 1)
                begin
                    m_rot[level_of(m_run)] = m_rot[level_of(m_run)] + 4'd1;
                    w.sw = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        w.cur = 5'(m_run);
        w.levels = m_levels;
        w.ticks = m_ticks;
        w.total = 5'(m_total);
        return w;
    endfunction

    // mostly short gaps, a few long ones, sometimes none
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 0;
        if (r < 92)
            return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    // send one command word and predict its result at acceptance
    task automatic send_word(logic [2:0] f, logic [5:0] p, logic [31:0] d);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            start <= 1'b0;
            repeat (g) @(posedge clk);
        end
        start <= 1'b1;
        func <= f;
        priority_req <= p;
        block_ticks <= d;
        do
            @(posedge clk);
        while (busy);
        expected_words.push_back(schedule_step(f, p, d));
        n_sent++;
    endtask

    // hold off until every result is back, then let the block settle
    task automatic wait_idle();
        start <= 1'b0;
        while (expected_words.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // result checker
    always @(posedge clk)
    begin
        sched_word_t e;
        if (rst_n && done)
        begin
            if (switch_request)
                n_switches++;
            if (expected_words.size() == 0)
            begin
                $display("%0t unexpected result word cur=%0d", $time, current_task);
                n_errors++;
            end
            else
            begin
                e = expected_words.pop_front();
                n_checked++;
                if (e.cur !== current_task || e.sw !== switch_request ||
                    e.err !== error_code || e.id !== new_task_id ||
                    e.levels !== ready_levels || e.ticks !== ticks_elapsed ||
                    e.total !== tasks_in_use)
                begin
                    $display("%0t mismatch exp cur=%0d sw=%0d err=%0d id=%0d lv=%h tk=%0d n=%0d",
                             $time, e.cur, e.sw, e.err, e.id, e.levels, e.ticks, e.total);
                    $display("%0t          got cur=%0d sw=%0d err=%0d id=%0d lv=%h tk=%0d n=%0d",
                             $time, current_task, switch_request, error_code, new_task_id,
                             ready_levels, ticks_elapsed, tasks_in_use);
                    n_errors++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge clk)
    begin
        if (!rst_n || done || (start && !busy))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG)
        begin
            $display("watchdog expired after %0d idle cycles", WDOG);
            $display("status: fail");
            $finish;
        end
    end

    // operations before any task runs, range errors, unknown codes
    task automatic test_before_start();
        send_word(prrts_pkg::FN_YIELD, 6'd0, 32'd0);
        send_word(prrts_pkg::FN_DELAY, 6'd0, 32'd5);
        send_word(prrts_pkg::FN_TICK, 6'd0, 32'd0);
        send_word(prrts_pkg::FN_CREATE, 6'd32, 32'd0);
        send_word(prrts_pkg::FN_CREATE, 6'd63, 32'hFFFF_FFFF);
        send_word(3'd5, 6'd63, 32'hFFFF_FFFF);
        send_word(3'd6, 6'd0, 32'd0);
        send_word(3'd7, 6'd21, 32'h5A5A_5A5A);
        send_word(prrts_pkg::FN_START, 6'd0, 32'd0);
        send_word(prrts_pkg::FN_DELAY, 6'd0, 32'd3);
    endtask

    // create, start, yield, delay, tick around peers at one level
    task automatic test_basic_ops();
        send_word(prrts_pkg::FN_CREATE, 6'd31, 32'd0);
        send_word(prrts_pkg::FN_CREATE, 6'd5, 32'd0);
        send_word(prrts_pkg::FN_CREATE, 6'd5, 32'd0);
        send_word(prrts_pkg::FN_START, 6'd0, 32'd0);
        send_word(prrts_pkg::FN_TICK, 6'd0, 32'd0);
        send_word(prrts_pkg::FN_YIELD, 6'd0, 32'd0);
        send_word(prrts_pkg::FN_DELAY, 6'd0, 32'd0);
        send_word(prrts_pkg::FN_DELAY, 6'd0, 32'd2);
        send_word(prrts_pkg::FN_DELAY, 6'd0, 32'd1);
        send_word(prrts_pkg::FN_CREATE, 6'd0, 32'd0);
        send_word(prrts_pkg::FN_TICK, 6'd0, 32'd0);
        send_word(prrts_pkg::FN_TICK, 6'd0, 32'd0);
        send_word(prrts_pkg::FN_DELAY, 6'd0, 32'hFFFF_FFFF);
        send_word(prrts_pkg::FN_TICK, 6'd0, 32'd0);
    endtask

    function automatic logic [31:0] random_delay();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        if (r < 97)
            return $urandom_range(1, 6);
        return $urandom;
    endfunction

    // random traffic; tasks fill the table slowly so early states are hit
    task automatic test_random_mix(int count);
        int r;
        for (int k = 0; k < count; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
                send_word(prrts_pkg::FN_CREATE, 6'($urandom_range(0, 63)), $urandom);
            else if (r < 12)
                send_word(prrts_pkg::FN_START, 6'($urandom), $urandom);
            else if (r < 30)
                send_word(prrts_pkg::FN_YIELD, 6'($urandom), $urandom);
            else if (r < 55)
                send_word(prrts_pkg::FN_DELAY, 6'($urandom), random_delay());
            else if (r < 97)
                send_word(prrts_pkg::FN_TICK, 6'($urandom), $urandom);
            else
                send_word(3'($urandom_range(5, 7)), 6'($urandom), $urandom);
            if (k == count / 2)
                wait_idle();
        end
    endtask

    // fill the task table and hit the full error
    task automatic test_fill_table();
        while (m_total < NT)
            send_word(prrts_pkg::FN_CREATE, 6'($urandom_range(0, 31)), 32'd0);
        send_word(prrts_pkg::FN_CREATE, 6'd3, 32'd0);
        send_word(prrts_pkg::FN_CREATE, 6'd40, 32'd0);
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        func = prrts_pkg::FN_CREATE;
        priority_req = '0;
        block_ticks = '0;
        m_levels = '0;
        m_run = NONE;
        m_total = 0;
        m_ticks = '0;
        n_sent = 0;
        n_checked = 0;
        n_errors = 0;
        n_switches = 0;
        quiet_cycles = 0;
        for (int i = 0; i < NT; i++)
        begin
            m_prio[i] = '0;
            m_state[i] = prrts_pkg::TS_SUSPENDED;
            m_wait[i] = '0;
        end
        for (int i = 0; i < NL; i++)
            m_rot[i] = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_before_start();
        test_basic_ops();
        test_random_mix(500);
        test_fill_table();
        test_random_mix(700);

        wait_idle();
        $display("covered %0d command words, %0d results checked, %0d switch requests",
                 n_sent, n_checked, n_switches);
        $display("final tick count %0d with %0d tasks created", m_ticks, m_total);
        if (n_errors == 0 && expected_words.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

/* priority_round_robin_task_scheduler.f */
sv/prrts_pkg.sv
sv/prrts_mod_unit.sv
sv/priority_round_robin_task_scheduler.sv
tb/sv/testbench.sv
